FILE: hdl/bbr_pkg.sv
// Shared types and constants for the box blur row engine.
package bbr_pkg;

	// fixed field widths of the pixel stream
	localparam int CHAN_W   = 8;
	localparam int POS_W    = 8;
	localparam int RADIUS_W = 6;

	localparam logic [POS_W-1:0]    POS_MAX      = 8'd255;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 6'd1;

	typedef logic [CHAN_W-1:0] chan_t;

	// one stored pixel
	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} rgb_t;

	// input request payload
	typedef struct packed {
		chan_t pixel_red;
		chan_t pixel_green;
		chan_t pixel_blue;
		logic  last_in_row;
	} pixel_in_t;

	// output request payload
	typedef struct packed {
		chan_t out_red;
		chan_t out_green;
		chan_t out_blue;
		logic  row_done;
	} pixel_out_t;

	// controller to datapath commands
	typedef struct packed {
		logic take;      // write incoming pixel into the window
		logic first_wr;  // incoming pixel opens the row
		logic start;     // set up a new output window sum
		logic tap;       // read one window tap
		logic div_load;  // load the dividers from the sums
		logic div_step;  // one restoring division step
		logic out_load;  // load the output register
		logic row_done;  // flag for the output being loaded
	} bbr_cmd_t;

endpackage

FILE: hdl/bbr_datapath.sv
// Datapath: pixel window memory, tap accumulators, serial dividers, output register.
module bbr_datapath import bbr_pkg::*; #(
	parameter int MAX_RADIUS = 63
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bbr_cmd_t                             cmd,
	input  logic [POS_W-1:0]                     pos,
	input  logic [$clog2(MAX_RADIUS+1)-1:0]      rad,
	input  logic [$clog2(MAX_RADIUS+1)-1:0]      back,
	input  pixel_in_t                            in_data,
	output pixel_out_t                           out_data
);

	localparam int R_W    = $clog2(MAX_RADIUS + 1);
	localparam int O_W    = $clog2(2 * MAX_RADIUS + 1);
	localparam int ADDR_W = $clog2(2 * MAX_RADIUS + 2);
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int SUM_W  = CHAN_W + $clog2(2 * MAX_RADIUS + 1);
	localparam int DIV_W  = R_W + 1;

	rgb_t               mem [DEPTH];
	logic [ADDR_W-1:0]  wptr_q;
	rgb_t               first_q;
	logic [O_W-1:0]     ofs_q;
	rgb_t               rd_s1;
	logic               sel_first_s1;
	logic               tap_vld_s1;
	rgb_t               tap_val;
	logic [DIV_W-1:0]   dvs_q;
	logic [SUM_W-1:0]   acc_q [3];
	logic [SUM_W-1:0]   quo_q [3];
	logic [DIV_W-1:0]   rem_q [3];
	logic [SUM_W-1:0]   tap_ext [3];
	logic [DIV_W:0]     trial [3];
	logic [DIV_W:0]     diff [3];
	logic               fits [3];
	pixel_out_t         out_q;

	// pointer to the newest pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q     <= '0;
			tap_vld_s1 <= 1'b0;
		end else begin
			if (cmd.take) begin
				wptr_q <= wptr_q + 1'b1;
			end
			tap_vld_s1 <= cmd.tap;
		end
	end

	// window memory: write on a new pixel, registered tap read
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mem[wptr_q + 1'b1] <= '{red: in_data.pixel_red, green: in_data.pixel_green,
				blue: in_data.pixel_blue};
		end
		if (cmd.tap) begin
			rd_s1 <= mem[wptr_q - ADDR_W'(ofs_q)];
		end
	end

	// first pixel of the row, tap offset and clamp flag
	always_ff @(posedge clk) begin
		if (cmd.first_wr) begin
			first_q <= '{red: in_data.pixel_red, green: in_data.pixel_green,
				blue: in_data.pixel_blue};
		end
		if (cmd.start) begin
			ofs_q <= O_W'(back) + O_W'(rad);
			dvs_q <= {rad, 1'b1};
		end else if (cmd.tap) begin
			// taps to the right of the newest pixel clamp to it
			ofs_q <= (ofs_q == '0) ? ofs_q : ofs_q - 1'b1;
		end
		if (cmd.tap) begin
			// taps left of the row start read the first pixel
			sel_first_s1 <= (POS_W'(ofs_q) > pos);
		end
	end

	// tap value and division trial per channel
	always_comb begin
		tap_val    = sel_first_s1 ? first_q : rd_s1;
		tap_ext[0] = SUM_W'(tap_val.red);
		tap_ext[1] = SUM_W'(tap_val.green);
		tap_ext[2] = SUM_W'(tap_val.blue);
		for (int c = 0; c < 3; c++) begin
			trial[c] = {rem_q[c], quo_q[c][SUM_W-1]};
			diff[c]  = trial[c] - {1'b0, dvs_q};
			fits[c]  = (trial[c] >= {1'b0, dvs_q});
		end
	end

	// accumulators and restoring dividers, one lane per channel
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			if (cmd.start) begin
				acc_q[c] <= '0;
			end else if (tap_vld_s1) begin
				acc_q[c] <= acc_q[c] + tap_ext[c];
			end
			if (cmd.div_load) begin
				rem_q[c] <= '0;
				quo_q[c] <= acc_q[c];
			end else if (cmd.div_step) begin
				rem_q[c] <= fits[c] ? diff[c][DIV_W-1:0] : trial[c][DIV_W-1:0];
				quo_q[c] <= {quo_q[c][SUM_W-2:0], fits[c]};
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.out_red   <= quo_q[0][CHAN_W-1:0];
			out_q.out_green <= quo_q[1][CHAN_W-1:0];
			out_q.out_blue  <= quo_q[2][CHAN_W-1:0];
			out_q.row_done  <= cmd.row_done;
		end
	end

	assign out_data = out_q;

endmodule

FILE: hdl/bbr_ctrl.sv
// Controller: row position, radius register and the per-output sequence.
module bbr_ctrl import bbr_pkg::*; #(
	parameter int MAX_RADIUS = 63
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 last_in_row,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic                                 cfg_we,
	input  logic [RADIUS_W-1:0]                  cfg_wdata,
	output bbr_cmd_t                             cmd,
	output logic [POS_W-1:0]                     pos,
	output logic [$clog2(MAX_RADIUS+1)-1:0]      rad,
	output logic [$clog2(MAX_RADIUS+1)-1:0]      back
);

	localparam int R_W    = $clog2(MAX_RADIUS + 1);
	localparam int O_W    = $clog2(2 * MAX_RADIUS + 1);
	localparam int SUM_W  = CHAN_W + $clog2(2 * MAX_RADIUS + 1);
	localparam int DCNT_W = $clog2(SUM_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_TAPS,
		ST_SETTLE,
		ST_DLOAD,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t              state;
	logic [RADIUS_W-1:0] radius_q;
	logic [R_W-1:0]      r_eff;
	logic [R_W-1:0]      r_q;
	logic [R_W-1:0]      back_q;
	logic                last_q;
	logic [POS_W-1:0]    row_pos_q;
	logic [POS_W-1:0]    pos_q;
	logic [O_W-1:0]      taps_q;
	logic [DCNT_W-1:0]   div_cnt_q;
	logic                out_vld_q;

	// radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	// radius in use, saturated to the largest supported
	always_comb begin
		if ({1'b0, radius_q} > 7'(MAX_RADIUS)) begin
			r_eff = R_W'(MAX_RADIUS);
		end else begin
			r_eff = R_W'(radius_q);
		end
	end

	// commands to the datapath
	always_comb begin
		cmd          = '0;
		cmd.take     = (state == ST_IDLE) && in_valid;
		cmd.first_wr = cmd.take && (row_pos_q == '0);
		cmd.start    = (state == ST_START);
		cmd.tap      = (state == ST_TAPS);
		cmd.div_load = (state == ST_DLOAD);
		cmd.div_step = (state == ST_DIV);
		cmd.out_load = (state == ST_EMIT) && (!out_vld_q || !out_stall);
		cmd.row_done = last_q && (back_q == '0);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state     <= ST_IDLE;
			r_q       <= '0;
			back_q    <= '0;
			last_q    <= 1'b0;
			row_pos_q <= '0;
			pos_q     <= '0;
			taps_q    <= '0;
			div_cnt_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// output register valid
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end

			unique case (state)
				ST_IDLE: begin
					if (in_valid) begin
						pos_q  <= row_pos_q;
						r_q    <= r_eff;
						last_q <= last_in_row;
						if (last_in_row) begin
							// flush: first pending output is min(r, pos) back
							back_q    <= (row_pos_q < POS_W'(r_eff)) ? R_W'(row_pos_q) : r_eff;
							row_pos_q <= '0;
							state     <= ST_START;
						end else begin
							back_q <= r_eff;
							if (row_pos_q != POS_MAX) begin
								row_pos_q <= row_pos_q + 1'b1;
							end
							state <= (row_pos_q >= POS_W'(r_eff)) ? ST_START : ST_IDLE;
						end
					end
				end
				ST_START: begin
					taps_q <= O_W'({r_q, 1'b0});
					state  <= ST_TAPS;
				end
				ST_TAPS: begin
					if (taps_q == '0) begin
						state <= ST_SETTLE;
					end else begin
						taps_q <= taps_q - 1'b1;
					end
				end
				ST_SETTLE: begin
					state <= ST_DLOAD;
				end
				ST_DLOAD: begin
					div_cnt_q <= DCNT_W'(SUM_W - 1);
					state     <= ST_DIV;
				end
				ST_DIV: begin
					if (div_cnt_q == '0) begin
						state <= ST_EMIT;
					end else begin
						div_cnt_q <= div_cnt_q - 1'b1;
					end
				end
				ST_EMIT: begin
					if (cmd.out_load) begin
						if (last_q && (back_q != '0)) begin
							back_q <= back_q - 1'b1;
							state  <= ST_START;
						end else begin
							state <= ST_IDLE;
						end
					end
				end
				default: begin
					state <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state != ST_IDLE);
	assign out_valid = out_vld_q;
	assign pos       = pos_q;
	assign rad       = r_q;
	assign back      = back_q;

	// window offset of a pending output never exceeds the radius
	a_back_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state != ST_IDLE) |-> (back_q <= r_q))
		else $error("output offset beyond radius");

	// the last pixel restarts the row and always produces output
	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && last_in_row) |=> (row_pos_q == '0 && state == ST_START))
		else $error("row end did not restart the row");

	// a pixel before the window fills produces nothing
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && !last_in_row && (row_pos_q < POS_W'(r_eff))) |=> (state == ST_IDLE))
		else $error("output started before window filled");

	// results appear only from the emit step
	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state == ST_EMIT))
		else $error("output valid without emit");

endmodule

FILE: hdl/box_blur_row_running_sum_core.sv
// Top level of the horizontal box blur for one streamed RGB row.
//
// Each accepted pixel is written to a window memory of 2^clog2(2*MAX_RADIUS+2)
// entries; no clearing pass is needed after reset. A pixel that does not
// complete a window is taken without starting an output sequence. For every
// blurred pixel, with r the radius in use and SUM_W = 8 + clog2(2*MAX_RADIUS+1)
// (15 at the default), the window is summed one tap per cycle from the
// single-port memory, and the three channel sums are divided by 2*r+1 in
// SUM_W-bit restoring dividers that retire one quotient bit per cycle. The pixel
// marked last in its row emits min(r, pos)+1 results one after another, each
// held while the result side stalls. Radius writes above MAX_RADIUS are
// saturated, and take effect for the next accepted pixel.
module box_blur_row_running_sum_core import bbr_pkg::*; #(
	parameter int MAX_RADIUS = 63
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pixel_in_t           in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output pixel_out_t          out_data,
	input  logic                cfg_we,
	input  logic [RADIUS_W-1:0] cfg_wdata
);

	localparam int R_W = $clog2(MAX_RADIUS + 1);

	bbr_cmd_t         cmd;
	logic [POS_W-1:0] pos;
	logic [R_W-1:0]   rad;
	logic [R_W-1:0]   back;

	// sequencer
	bbr_ctrl #(
		.MAX_RADIUS(MAX_RADIUS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.last_in_row (in_data.last_in_row),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.pos         (pos),
		.rad         (rad),
		.back        (back)
	);

	// window store, sums and dividers
	bbr_datapath #(
		.MAX_RADIUS(MAX_RADIUS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.pos      (pos),
		.rad      (rad),
		.back     (back),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule

FILE: dv/testbench.sv
// Testbench for the box blur row core: predicted blur results checked for directed and random pixel rows.
module testbench;
	import bbr_pkg::*;

	localparam int MAX_R           = 63;
	localparam int WIN_DEPTH       = 2 * MAX_R + 2;
	// leave margin after the last result of the slowest blurred pixel
	localparam int DRAIN_CYCLES    = 2 * MAX_R + 60;
	localparam int HOLD_CYCLES     = 400;
	localparam int RANDOM_PIXELS   = 104;
	localparam int LONG_ROW_PIXELS = 40;

	// Predicts blurred pixels for each accepted request and checks returned ones.
	class blur_row_checker;
		rgb_t       window[WIN_DEPTH];
		rgb_t       row_first;
		int         row_pos;
		int         radius;
		pixel_out_t expected_px[$];
		int         mismatches;

		function new();
			foreach (window[i])
				window[i] = '0;
			row_first  = '0;
			row_pos    = 0;
			radius     = RADIUS_RESET;
			mismatches = 0;
		endfunction

		function void set_radius(input int r);
			radius = r;
		endfunction

		function int pending();
			return expected_px.size();
		endfunction

		// pixel 'o' places behind the newest one, clamped to the row's first pixel
		function rgb_t tap(input int o);
			if (o > row_pos || o >= WIN_DEPTH)
				return row_first;
			return window[o];
		endfunction

		// mean of the window centered 'back' places behind the newest pixel
		function pixel_out_t window_mean(input int back, input int r, input bit done);
			pixel_out_t res;
			rgb_t       px;
			int         div, o, sum_r, sum_g, sum_b;
			div   = 2 * r + 1;
			sum_r = 0;
			sum_g = 0;
			sum_b = 0;
			for (int k = 0; k < div; k++) begin
				// positions past the newest pixel clamp to it
				o = (back + r >= k) ? back + r - k : 0;
				px = tap(o);
				sum_r += px.red;
				sum_g += px.green;
				sum_b += px.blue;
			end
			res.out_red   = chan_t'(sum_r / div);
			res.out_green = chan_t'(sum_g / div);
			res.out_blue  = chan_t'(sum_b / div);
			res.row_done  = done;
			return res;
		endfunction

		function void take_pixel(input pixel_in_t p);
			int r, back;
			r = (radius > MAX_R) ? MAX_R : radius;
			for (int i = WIN_DEPTH - 1; i > 0; i--)
				window[i] = window[i-1];
			window[0] = {p.pixel_red, p.pixel_green, p.pixel_blue};
			if (row_pos == 0)
				row_first = window[0];
			if (!p.last_in_row) begin
				if (row_pos >= r)
					expected_px.push_back(window_mean(r, r, 1'b0));
				if (row_pos < POS_MAX)
					row_pos++;
			end else begin
				// flush every pending output, row_done on the final one
				back = (row_pos < r) ? row_pos : r;
				for (int b = back; b >= 0; b--)
					expected_px.push_back(window_mean(b, r, b == 0));
				row_pos = 0;
			end
		endfunction

		function void match_output(input pixel_out_t got);
			pixel_out_t want;
			if (expected_px.size() == 0) begin
				$error("blurred pixel %h arrived with none expected", got);
				mismatches++;
				return;
			end
			want = expected_px.pop_front();
			if (got.out_red !== want.out_red) begin
				$error("out_red: expected %0d, actual %0d", want.out_red, got.out_red);
				mismatches++;
			end
			if (got.out_green !== want.out_green) begin
				$error("out_green: expected %0d, actual %0d", want.out_green, got.out_green);
				mismatches++;
			end
			if (got.out_blue !== want.out_blue) begin
				$error("out_blue: expected %0d, actual %0d", want.out_blue, got.out_blue);
				mismatches++;
			end
			if (got.row_done !== want.row_done) begin
				$error("row_done: expected %0b, actual %0b", want.row_done, got.row_done);
				mismatches++;
			end
		endfunction
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	pixel_in_t           in_data   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	pixel_out_t          out_data;
	logic                cfg_we    = 1'b0;
	logic [RADIUS_W-1:0] cfg_wdata = '0;

	blur_row_checker blur_model   = new();
	int              pixels_taken = 0;
	int              hold_mark    = 32'h7fff_ffff;
	bit              no_gaps      = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	box_blur_row_running_sum_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// idle run length: mostly none or short, now and then long
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// channel value with the extremes favored
	function automatic chan_t any_chan();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return chan_t'($urandom);
	endfunction

	// offer one pixel request and hold it until accepted; valid stays high afterwards
	task automatic send_pixel(input chan_t red, input chan_t green, input chan_t blue,
			input logic last);
		int gap;
		gap = no_gaps ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{pixel_red: red, pixel_green: green, pixel_blue: blue, last_in_row: last};
		do
			@(posedge clk);
		while (in_stall);
		blur_model.take_pixel(in_data);
		pixels_taken++;
	endtask

	task automatic send_row(input int len, input bit close);
		for (int i = 0; i < len; i++)
			send_pixel(any_chan(), any_chan(), any_chan(), close && (i == len - 1));
	endtask

	// wait for every expected result, then let the core settle
	task automatic drain();
		in_valid <= 1'b0;
		while (blur_model.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_radius(input int r);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= RADIUS_W'(r);
		@(posedge clk);
		cfg_we <= 1'b0;
		blur_model.set_radius(r);
	endtask

	// result side: random stalls, calm stretches, and one long hold-off
	initial begin : result_sink
		int run, calm;
		bit stalling, held;
		run      = 0;
		calm     = 0;
		stalling = 1'b0;
		held     = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				blur_model.match_output(out_data);
			if (!held && pixels_taken >= hold_mark) begin
				held     = 1'b1;
				stalling = 1'b1;
				run      = HOLD_CYCLES;
			end
			if (run > 0) begin
				run--;
			end else if (calm > 0) begin
				calm--;
				stalling = 1'b0;
			end else if ($urandom_range(0, 19) == 0) begin
				calm     = $urandom_range(50, 200);
				stalling = 1'b0;
			end else begin
				stalling = !stalling;
				run      = stalling ? idle_len() : $urandom_range(0, 6);
			end
			out_stall <= stalling;
		end
	end

	initial begin : stimulus
		int r, rows, len, budget, roll;
		bit open_end;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset radius: single-pixel row, then a row of extremes
		send_pixel('1, '1, '1, 1'b1);
		send_pixel('0, '1, '0, 1'b0);
		send_pixel('1, '0, '1, 1'b0);
		send_pixel(8'h80, 8'h7f, 8'h01, 1'b1);

		// zero radius passes pixels through
		write_radius(0);
		send_pixel(8'h55, 8'haa, 8'h0f, 1'b0);
		send_pixel('1, '1, '0, 1'b1);

		// largest radius on a short row: both edge clamps at once
		write_radius(MAX_R);
		send_pixel('1, '0, '0, 1'b0);
		send_pixel('0, '1, '0, 1'b0);
		send_pixel('0, '0, '1, 1'b0);
		send_pixel('1, '1, '1, 1'b1);

		// radius changed in the middle of a row
		write_radius(2);
		send_pixel(8'h10, 8'h20, 8'h30, 1'b0);
		send_pixel('1, '1, '1, 1'b0);
		send_pixel(8'h01, 8'hfe, 8'h7f, 1'b0);
		write_radius(1);
		send_pixel('0, '0, '0, 1'b0);
		send_pixel(8'hc3, 8'h3c, 8'h99, 1'b0);
		send_pixel('1, '0, '1, 1'b1);

		// back-to-back row with the receiver held off to back up the core
		write_radius(0);
		hold_mark = pixels_taken + 4;
		no_gaps   = 1'b1;
		send_row(LONG_ROW_PIXELS, 1'b1);
		no_gaps   = 1'b0;

		// random radius phases of random rows; some rows stay open across a radius change
		budget = pixels_taken + RANDOM_PIXELS;
		while (pixels_taken < budget) begin
			roll = $urandom_range(0, 19);
			if (roll < 4)
				r = 0;
			else if (roll < 7)
				r = MAX_R;
			else if (roll < 9)
				r = $urandom_range(7, MAX_R - 1);
			else
				r = $urandom_range(1, 6);
			write_radius(r);
			no_gaps = ($urandom_range(0, 3) == 0);
			rows    = $urandom_range(1, 3);
			for (int i = 0; i < rows; i++) begin
				if (r >= 32 && $urandom_range(0, 2) == 0)
					len = $urandom_range(r + 1, r + 4);
				else
					len = $urandom_range(1, (2 * r + 6 < 24) ? 2 * r + 6 : 24);
				open_end = (i == rows - 1) && ($urandom_range(0, 4) == 0);
				send_row(len, !open_end);
			end
		end
		no_gaps = 1'b0;

		drain();
		if (blur_model.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// run limit
	initial begin : watchdog
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
